@@ hw/rtl/lcs_pkg.sv @@
// Shared types and constants for the line column span block.
`timescale 1ns / 1ps
package lcs_pkg;

  localparam int COORD_BITS = 16;
  // quotient magnitude bits: |floor(y)| stays below 2^(COORD_BITS+1)
  localparam int QUOT_BITS  = COORD_BITS + 1;
  localparam int QUOT_SBITS = QUOT_BITS + 1;
  // denominator 2*dx
  localparam int DEN_BITS   = COORD_BITS + 2;
  // numerator (2*ay+1)*dx + dy*t, signed
  localparam int NUM_BITS   = 2 * COORD_BITS + 4;
  localparam int BASE_BITS  = 2 * COORD_BITS + 2;
  localparam int T_BITS     = COORD_BITS + 3;
  localparam int D_BITS     = COORD_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    REG_START_X,
    REG_START_Y,
    REG_END_X,
    REG_END_Y
  } reg_idx_e;

  // per-item side data carried alongside the dividers
  typedef struct packed {
    logic   in_range;
    logic   vert;
    coord_t ylo;
    coord_t yhi;
    coord_t py;
  } meta_t;

endpackage

@@ hw/rtl/lcs_if.sv @@
// Channel interfaces: query input, result output, register writes.
`timescale 1ns / 1ps
interface lcs_in_if import lcs_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t column_x;
  coord_t point_y;
  modport source (output valid, column_x, point_y, input ready);
  modport sink (input valid, column_x, point_y, output ready);
endinterface

interface lcs_out_if import lcs_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   in_span;
  coord_t span_low;
  coord_t span_high;
  logic   on_line;
  modport source (output valid, in_span, span_low, span_high, on_line, input ready);
  modport sink (input valid, in_span, span_low, span_high, on_line, output ready);
endinterface

interface lcs_cfg_if import lcs_pkg::*; ();
  logic     valid;
  logic     ready;
  reg_idx_e index;
  coord_t   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/lcs_fdiv.sv @@
// Pipelined floor divider, one quotient bit per stage, positive divisor.
`timescale 1ns / 1ps
module lcs_fdiv import lcs_pkg::*; (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [NUM_BITS-2:0]          mag_i,   // N, or ~N when N < 0
  input  logic                         neg_i,
  input  logic [DEN_BITS-1:0]          den_i,
  output logic signed [QUOT_SBITS-1:0] quot_o
);

  logic [DEN_BITS-1:0]  rem_q [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] num_q [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] qt_q  [QUOT_BITS+1];
  logic [DEN_BITS-1:0]  den_q [QUOT_BITS+1];
  logic                 neg_q [QUOT_BITS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= mag_i[NUM_BITS-2:QUOT_BITS];
      num_q[0] <= mag_i[QUOT_BITS-1:0];
      qt_q[0]  <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
    end
  end

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
    logic [DEN_BITS:0]   trial;
    logic                take;
    logic [DEN_BITS-1:0] rem_d;

    always_comb begin
      trial = {rem_q[k], num_q[k][QUOT_BITS-1]};
      take  = (trial >= {1'b0, den_q[k]});
      rem_d = take ? DEN_BITS'(trial - {1'b0, den_q[k]}) : trial[DEN_BITS-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= rem_d;
        num_q[k+1] <= {num_q[k][QUOT_BITS-2:0], 1'b0};
        qt_q[k+1]  <= {qt_q[k][QUOT_BITS-2:0], take};
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  // floor(N/D) = ~floor(~N/D) for negative N
  assign quot_o = neg_q[QUOT_BITS] ? ~{1'b0, qt_q[QUOT_BITS]} : {1'b0, qt_q[QUOT_BITS]};

endmodule

@@ hw/rtl/line_column_span.sv @@
// Top level: column span of a rasterized line segment between two grid points.
//
//   channel | dir | payload                                 | handshake
//   in_i    | in  | column_x, point_y                       | valid/ready
//   cfg_i   | in  | index (start_x,start_y,end_x,end_y), data| valid/ready
//   out_o   | out | in_span, span_low, span_high, on_line   | valid/ready
//
// One transaction per cycle sustained while out_o is not stalled. The path from
// input to output register runs through setup, the two bit-serial floor dividers
// (one quotient bit per stage, COORD_BITS+1 stages) and the finish stage.
// cfg_i is always ready; registers reset to 0 on rst_ni (async, active low).
// A stall on out_o freezes the whole pipeline; in_i.ready follows it.
`timescale 1ns / 1ps
module line_column_span import lcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcs_in_if.sink      in_i,
  lcs_cfg_if.sink     cfg_i,
  lcs_out_if.source   out_o
);

  localparam int W = COORD_BITS;

  // ---------------- configuration registers ----------------
  coord_t sx_q, sy_q, ex_q, ey_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0;
      sy_q <= '0;
      ex_q <= '0;
      ey_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_START_X: sx_q <= cfg_i.data;
        REG_START_Y: sy_q <= cfg_i.data;
        REG_END_X:   ex_q <= cfg_i.data;
        REG_END_Y:   ey_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Global advance: move when the output register is free or being drained.
  logic en;
  logic out_v_q;
  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  // ---------------- stage 1: order endpoints, set up terms ----------------
  coord_t                    ax, ay, bx, by;
  logic                      swap;
  logic signed [W:0]         xa;
  meta_t                     m1_d, m1_q;
  logic signed [T_BITS-1:0]  t0_d, t0_q;
  logic signed [W:0]         ay2_d, ay2_q, dx_d, dx_q, dy_d, dy_q;
  logic                      v1_q;

  always_comb begin
    swap  = ex_q < sx_q;
    ax    = swap ? ex_q : sx_q;
    ay    = swap ? ey_q : sy_q;
    bx    = swap ? sx_q : ex_q;
    by    = swap ? sy_q : ey_q;
    xa    = (W+1)'(in_i.column_x) - (W+1)'(ax);
    t0_d  = ((T_BITS)'(xa) <<< 1) - (T_BITS)'(1);     // 2*(x-ax)-1
    ay2_d = ((W+1)'(ay) <<< 1) + (W+1)'(1);           // 2*ay+1
    dx_d  = (W+1)'(bx) - (W+1)'(ax);
    dy_d  = (W+1)'(by) - (W+1)'(ay);
    m1_d.in_range = (in_i.column_x >= ax) && (in_i.column_x <= bx);
    m1_d.vert     = (ax == bx);
    m1_d.ylo      = (ay < by) ? ay : by;
    m1_d.yhi      = (ay < by) ? by : ay;
    m1_d.py       = in_i.point_y;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q  <= m1_d;
      t0_q  <= t0_d;
      ay2_q <= ay2_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [BASE_BITS-1:0] base_d, base_q;
  logic signed [NUM_BITS-1:0]  p0_d, p0_q;
  logic signed [W:0]           dy2_q;
  logic [DEN_BITS-1:0]         den2_q;
  meta_t                       m2_q;
  logic                        v2_q;

  assign base_d = ay2_q * dx_q;
  assign p0_d   = dy_q * t0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      base_q <= base_d;
      p0_q   <= p0_d;
      dy2_q  <= dy_q;
      den2_q <= {dx_q, 1'b0};
      m2_q   <= m1_q;
    end
  end

  // ---------------- numerators into the dividers ----------------
  // N0 = (2ay+1)dx + dy*t0, N1 = N0 + 2dy, both over 2dx
  logic signed [NUM_BITS-1:0] n0, n1;
  logic [NUM_BITS-2:0]        mag0, mag1;

  always_comb begin
    n0   = NUM_BITS'(base_q) + p0_q;
    n1   = n0 + (NUM_BITS'(dy2_q) <<< 1);
    mag0 = n0[NUM_BITS-1] ? ~n0[NUM_BITS-2:0] : n0[NUM_BITS-2:0];
    mag1 = n1[NUM_BITS-1] ? ~n1[NUM_BITS-2:0] : n1[NUM_BITS-2:0];
  end

  logic signed [QUOT_SBITS-1:0] q0, q1;

  lcs_fdiv u_div0 (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (mag0),
    .neg_i  (n0[NUM_BITS-1]),
    .den_i  (den2_q),
    .quot_o (q0)
  );

  lcs_fdiv u_div1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (mag1),
    .neg_i  (n1[NUM_BITS-1]),
    .den_i  (den2_q),
    .quot_o (q1)
  );

  // side data delayed to line up with the divider outputs
  meta_t md_q [QUOT_BITS+1];
  logic [QUOT_BITS:0] vd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q[0] <= m2_q;
      for (int k = 0; k < QUOT_BITS; k++) begin
        md_q[k+1] <= md_q[k];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vd_q <= '0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      vd_q <= {vd_q[QUOT_BITS-1:0], v2_q};
    end
  end

  // ---------------- finish: clamp, order, test point ----------------
  meta_t                        mf;
  logic signed [QUOT_SBITS-1:0] lo_w, hi_w, c0, c1;
  coord_t                       f0, f1, lo_d, hi_d;
  logic                         on_d;

  always_comb begin
    mf   = md_q[QUOT_BITS];
    lo_w = QUOT_SBITS'(mf.ylo);
    hi_w = QUOT_SBITS'(mf.yhi);
    c0   = (q0 < lo_w) ? lo_w : ((q0 > hi_w) ? hi_w : q0);
    c1   = (q1 < lo_w) ? lo_w : ((q1 > hi_w) ? hi_w : q1);
    f0   = W'(c0);
    f1   = W'(c1);
    if (mf.vert) begin
      // vertical segment: whole y extent in its column
      lo_d = mf.ylo;
      hi_d = mf.yhi;
    end else begin
      lo_d = (f0 > f1) ? f1 : f0;
      hi_d = (f0 > f1) ? f0 : f1;
    end
    if (!mf.in_range) begin
      lo_d = '0;
      hi_d = '0;
    end
    on_d = mf.in_range && (mf.py >= lo_d) && (mf.py <= hi_d);
  end

  logic   in_span_q, on_line_q;
  coord_t span_low_q, span_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vd_q[QUOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_span_q   <= mf.in_range;
      span_low_q  <= lo_d;
      span_high_q <= hi_d;
      on_line_q   <= on_d;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.in_span   = in_span_q;
  assign out_o.span_low  = span_low_q;
  assign out_o.span_high = span_high_q;
  assign out_o.on_line   = on_line_q;

endmodule

@@ tb/tb_line_column_span.sv @@
// Self-checking testbench for line_column_span: directed table, then random queries.
`timescale 1ns / 1ps
module tb_line_column_span;
  import lcs_pkg::*;

  // ---------------------------------------------------------------------------
  // Types
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic   in_span;
    coord_t span_low;
    coord_t span_high;
    logic   on_line;
  } span_res_t;

  // A row of the directed table. When load is set, the segment endpoints are
  // written first, with the block drained. When known is set, the expected
  // result is typed in the row instead of coming from the span predictor.
  typedef struct packed {
    logic      load;
    coord_t    sx;
    coord_t    sy;
    coord_t    ex;
    coord_t    ey;
    coord_t    qx;
    coord_t    qy;
    logic      known;
    span_res_t res;
  } dir_row_t;

  typedef struct packed {
    logic      known;
    span_res_t res;
  } typed_t;

  localparam int NDIR = 20;
  // pipeline depth plus margin, from the register stages of the block
  localparam int DRAIN_CYCLES = COORD_BITS + 12;
  localparam int NRAND = 530;

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  lcs_in_if  in_ch ();
  lcs_cfg_if cfg_ch ();
  lcs_out_if out_ch ();

  line_column_span dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .cfg_i  (cfg_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow registers and span predictor
  // ---------------------------------------------------------------------------
  coord_t seg_reg [4];

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Column span of the segment held in seg_reg, through the cell centers.
  function automatic span_res_t predict_span(coord_t qx, coord_t qy);
    longint ax, ay, bx, by, t, ylo, yhi, lo, hi;
    longint dx, dy, den, base, t0, f0, f1;
    span_res_t r;
    ax = seg_reg[REG_START_X];
    ay = seg_reg[REG_START_Y];
    bx = seg_reg[REG_END_X];
    by = seg_reg[REG_END_Y];
    r  = '0;
    // reversed endpoints describe the same line
    if (bx < ax) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    ylo = (ay < by) ? ay : by;
    yhi = (ay < by) ? by : ay;
    if (qx >= ax && qx <= bx) begin
      if (ax == bx) begin
        // vertical segment or single point: whole y extent
        lo = ylo;
        hi = yhi;
      end else begin
        dx   = bx - ax;
        dy   = by - ay;
        den  = 2 * dx;
        base = (2 * ay + 1) * dx;
        t0   = 2 * (longint'(qx) - ax) - 1;
        f0   = clip(floor_quot(base + dy * t0, den), ylo, yhi);
        f1   = clip(floor_quot(base + dy * (t0 + 2), den), ylo, yhi);
        lo   = (f0 < f1) ? f0 : f1;
        hi   = (f0 < f1) ? f1 : f0;
      end
      r.in_span   = 1'b1;
      r.span_low  = coord_t'(lo);
      r.span_high = coord_t'(hi);
      r.on_line   = (qy >= lo && qy <= hi);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: expectations taken at input acceptance, checked at output
  // ---------------------------------------------------------------------------
  span_res_t expected_spans [$];
  typed_t    typed_q [$];
  int        n_errors;
  int        n_queries;
  int        n_checked;
  int        n_inspan;
  int        n_online;
  int        n_cfg;

  always @(posedge clk_i) begin
    span_res_t p;
    typed_t    tv;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      p  = predict_span(in_ch.column_x, in_ch.point_y);
      tv = typed_q.pop_front();
      if (tv.known) p = tv.res;
      expected_spans = {expected_spans, p};
      n_queries++;
    end
    // register writes land in the shadow copy on the same edge
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) begin
      seg_reg[cfg_ch.index] <= cfg_ch.data;
      n_cfg++;
    end
  end

  always @(posedge clk_i) begin
    span_res_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_spans.size() == 0) begin
        $display("%0t: unexpected result in_span=%0d low=%0d high=%0d on_line=%0d",
                 $time, out_ch.in_span, out_ch.span_low, out_ch.span_high,
                 out_ch.on_line);
        n_errors++;
      end else begin
        e = expected_spans.pop_front();
        n_checked++;
        if (e.in_span) n_inspan++;
        if (e.on_line) n_online++;
        if (out_ch.in_span !== e.in_span) begin
          $display("%0t: in_span expected %0d actual %0d", $time, e.in_span,
                   out_ch.in_span);
          n_errors++;
        end
        if (out_ch.span_low !== e.span_low) begin
          $display("%0t: span_low expected %0d actual %0d", $time, e.span_low,
                   out_ch.span_low);
          n_errors++;
        end
        if (out_ch.span_high !== e.span_high) begin
          $display("%0t: span_high expected %0d actual %0d", $time, e.span_high,
                   out_ch.span_high);
          n_errors++;
        end
        if (out_ch.on_line !== e.on_line) begin
          $display("%0t: on_line expected %0d actual %0d", $time, e.on_line,
                   out_ch.on_line);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per phase, plus a long hold-off for back-pressure
  // ---------------------------------------------------------------------------
  int   stall_pct;
  int   idle_pct;
  logic hold_off;

  always @(negedge clk_i) begin
    out_ch.ready = !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Drivers (all inputs change on the falling edge)
  // ---------------------------------------------------------------------------
  task automatic send_query(coord_t qx, coord_t qy, logic known, span_res_t res);
    typed_t tv;
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    tv.known = known;
    tv.res   = res;
    typed_q = {typed_q, tv};
    in_ch.valid    = 1'b1;
    in_ch.column_x = qx;
    in_ch.point_y  = qy;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(reg_idx_e idx, coord_t val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // wait until every query has come back, then let the pipeline settle
  task automatic drain();
    while (expected_spans.size() != 0 || typed_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    drain();
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
  endtask

  function automatic coord_t sat16(longint v);
    return coord_t'(clip(v, -32768, 32767));
  endfunction

  // Random segment: mostly short ones, some vertical, points and full range.
  task automatic random_segment();
    longint ax, ay;
    ax = $signed(16'($urandom));
    ay = $signed(16'($urandom));
    case ($urandom_range(9))
      0: load_segment(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      1: load_segment(coord_t'(ax), coord_t'(ay), coord_t'(ax), 16'($urandom));
      2: load_segment(coord_t'(ax), coord_t'(ay), coord_t'(ax), coord_t'(ay));
      3: load_segment(16'h8000, 16'($urandom), 16'h7fff, 16'($urandom));
      default: load_segment(coord_t'(ax), coord_t'(ay),
                            sat16(ax + $signed($urandom_range(600)) - 300),
                            sat16(ay + $signed($urandom_range(2000)) - 1000));
    endcase
  endtask

  // Query mostly inside or just around the x extent, with y near the span.
  task automatic random_query();
    longint xl, xh, qx, qy;
    span_res_t p;
    if ($urandom_range(9) == 0) begin
      send_query(16'($urandom), 16'($urandom), 1'b0, '0);
    end else begin
      xl = (seg_reg[REG_START_X] < seg_reg[REG_END_X]) ?
           seg_reg[REG_START_X] : seg_reg[REG_END_X];
      xh = (seg_reg[REG_START_X] < seg_reg[REG_END_X]) ?
           seg_reg[REG_END_X] : seg_reg[REG_START_X];
      qx = clip(xl - 3 + longint'($urandom_range(32'(clip(xh - xl + 6, 0, 70000)))),
                -32768, 32767);
      p  = predict_span(coord_t'(qx), '0);
      if (p.in_span)
        qy = clip(longint'(p.span_low) - 2 +
                  longint'($urandom_range(32'(longint'(p.span_high) - p.span_low + 4))),
                  -32768, 32767);
      else
        qy = $signed(16'($urandom));
      send_query(coord_t'(qx), coord_t'(qy), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  localparam span_res_t OUT_OF_SPAN = '0;
  dir_row_t dir_tab [NDIR] = '{
    // reset state: single point at the origin
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{1'b1, 16'sd0, 16'sd0, 1'b1}},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 1'b1,
      '{1'b1, 16'sd0, 16'sd0, 1'b0}},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b1, OUT_OF_SPAN},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd32767, 1'b1, OUT_OF_SPAN},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 1'b1, OUT_OF_SPAN},
    // single point away from the origin
    '{1'b1, 16'sd5, -16'sd7, 16'sd5, -16'sd7, 16'sd5, -16'sd7, 1'b1,
      '{1'b1, -16'sd7, -16'sd7, 1'b1}},
    // vertical segment
    '{1'b1, 16'sd100, 16'sd40, 16'sd100, -16'sd20, 16'sd100, 16'sd40, 1'b1,
      '{1'b1, -16'sd20, 16'sd40, 1'b1}},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd101, 16'sd0, 1'b1, OUT_OF_SPAN},
    // full-range diagonal given in reverse x order
    '{1'b1, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
      1'b0, OUT_OF_SPAN},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 1'b0, OUT_OF_SPAN},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, OUT_OF_SPAN},
    // steepest possible segment
    '{1'b1, 16'sd0, -16'sd32768, 16'sd1, 16'sd32767, 16'sd0, 16'sd5, 1'b0, OUT_OF_SPAN},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd32767, 1'b0, OUT_OF_SPAN},
    // shallow, falling, full x range
    '{1'b1, -16'sd32768, 16'sd5, 16'sd32767, -16'sd6, -16'sd100, 16'sd0, 1'b0,
      OUT_OF_SPAN},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd6, 1'b0, OUT_OF_SPAN},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd5, 1'b0, OUT_OF_SPAN},
    // horizontal segment
    '{1'b1, -16'sd10, 16'sd3, 16'sd10, 16'sd3, 16'sd0, 16'sd3, 1'b1,
      '{1'b1, 16'sd3, 16'sd3, 1'b1}},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd11, 16'sd3, 1'b1, OUT_OF_SPAN},
    // extreme corner to corner, falling
    '{1'b1, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 1'b0,
      OUT_OF_SPAN},
    '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 1'b0, OUT_OF_SPAN}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase_idle [4];
    int phase_stall [4];
    phase_idle  = '{0, 72, 0, 35};
    phase_stall = '{0, 0, 72, 35};
    n_errors = 0; n_queries = 0; n_checked = 0;
    n_inspan = 0; n_online = 0; n_cfg = 0;
    foreach (seg_reg[i]) seg_reg[i] = '0;
    stall_pct      = 0;
    idle_pct       = 0;
    hold_off       = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.column_x = '0;
    in_ch.point_y  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_START_X;
    cfg_ch.data    = '0;
    rst_ni         = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].load)
        load_segment(dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].ex, dir_tab[i].ey);
      send_query(dir_tab[i].qx, dir_tab[i].qy, dir_tab[i].known, dir_tab[i].res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      // back-pressure: receiver stops for a long stretch while queries keep coming
      if (ph == 0) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (150) @(negedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < NRAND / 4; k++) begin
        if (k % 12 == 0) random_segment();
        random_query();
      end
    end
    stall_pct = 0;
    drain();

    $display("Covered %0d queries (%0d in span, %0d on line) over %0d register writes,",
             n_queries, n_inspan, n_online, n_cfg);
    $display("with idle and stall phases and a long output hold-off; %0d checked.",
             n_checked);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
